// File: hdl/base64_stream_decoder_unit_assert.svh
// Assertion macros shared by the base64 decoder modules.
`ifndef BASE64_STREAM_DECODER_UNIT_ASSERT_SVH
`define BASE64_STREAM_DECODER_UNIT_ASSERT_SVH

// Checks a condition at every clock edge outside reset.
`define B64D_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next.
`define B64D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/b64d_pkg.sv
// Types, constants and the character classifier of the base64 decoder.
`default_nettype none

package b64d_pkg;

  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 4;

  localparam logic [1:0] KIND_SKIP   = 2'd0;
  localparam logic [1:0] KIND_SEXTET = 2'd1;
  localparam logic [1:0] KIND_PAD    = 2'd2;
  localparam logic [1:0] KIND_BAD    = 2'd3;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  localparam logic [5:0] SEXTET_LOWER = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT = 6'd52;
  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] sextet;
    logic       eos;
  } cmd_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] byte_value;
    logic       success;
    logic       last;
  } res_t;

  function automatic cmd_t classify(logic [7:0] c, logic nc, logic eos);
    cmd_t cmd;
    logic [7:0] diff;
    cmd.kind   = KIND_BAD;
    cmd.sextet = '0;
    cmd.eos    = eos;
    diff       = '0;
    if (nc || c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      cmd.kind = KIND_SKIP;
    end else if (c == CH_EQUAL) begin
      cmd.kind = KIND_PAD;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      diff       = c - CH_UPPER_A;
      cmd.kind   = KIND_SEXTET;
      cmd.sextet = diff[5:0];
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      diff       = c - CH_LOWER_A;
      cmd.kind   = KIND_SEXTET;
      cmd.sextet = diff[5:0] + SEXTET_LOWER;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      diff       = c - CH_ZERO;
      cmd.kind   = KIND_SEXTET;
      cmd.sextet = diff[5:0] + SEXTET_DIGIT;
    end else if (c == CH_PLUS) begin
      cmd.kind   = KIND_SEXTET;
      cmd.sextet = SEXTET_PLUS;
    end else if (c == CH_SLASH) begin
      cmd.kind   = KIND_SEXTET;
      cmd.sextet = SEXTET_SLASH;
    end
    return cmd;
  endfunction

endpackage

`default_nettype wire

// File: hdl/b64d_front.sv
// Front end: classifies each input character and queues it for the back end.
`default_nettype none

module b64d_front #(
  parameter int CMD_DEPTH = b64d_pkg::CMD_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire logic [7:0]     char_code,
  input  wire logic           no_char,
  input  wire logic           end_of_string,
  output logic                cmd_valid,
  output b64d_pkg::cmd_t      cmd,
  input  wire logic           cmd_pop
);

`include "base64_stream_decoder_unit_assert.svh"

  localparam int AW = $clog2(CMD_DEPTH);
  localparam int CW = $clog2(CMD_DEPTH + 1);

  b64d_pkg::cmd_t slots [CMD_DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;

  assign full      = (count == CW'(CMD_DEPTH));
  assign do_push   = push && !full;
  assign cmd_valid = (count != '0);
  assign cmd       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= b64d_pkg::classify(char_code, no_char, end_of_string);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= (rd_ptr == AW'(CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, cmd_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `B64D_ASSERT(a_cmd_pop_nonempty, !cmd_pop || cmd_valid, "Command popped from an empty queue.")
  `B64D_ASSERT_NEXT(a_cmd_fill, do_push && !cmd_pop, count != '0 && count <= CW'(CMD_DEPTH), "Command queue count went wrong after a push.")

endmodule

`default_nettype wire

// File: hdl/b64d_back.sv
// Back end: decoding state, byte assembly, status and the result queue.
`default_nettype none

module b64d_back #(
  parameter int RES_DEPTH = b64d_pkg::RES_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  input  wire b64d_pkg::cmd_t cmd,
  output logic                cmd_pop,
  output logic                empty,
  input  wire logic           pop,
  output b64d_pkg::res_t      res
);

`include "base64_stream_decoder_unit_assert.svh"

  localparam int AW = $clog2(RES_DEPTH);
  localparam int CW = $clog2(RES_DEPTH + 1);

  logic [11:0] bit_accumulator, bit_accumulator_next;
  logic [3:0]  pending_bits, pending_bits_next;
  logic [1:0]  pad_count, pad_count_next;
  logic        pad_seen, pad_seen_next;
  logic [1:0]  length_mod_four, length_mod_four_next;
  logic        failed, failed_next;

  b64d_pkg::res_t slots [RES_DEPTH];
  logic [AW-1:0]  wr_ptr, wr_ptr1, wr_ptr2, rd_ptr;
  logic [CW-1:0]  count;
  logic           do_pop;
  logic           emit_byte;
  logic           emit_status;
  logic [1:0]     n_write;
  logic [11:0]    shifted;
  logic [3:0]     sum_bits;
  logic           ok;
  b64d_pkg::res_t byte_res, status_res;

  assign cmd_pop = cmd_valid && (count <= CW'(RES_DEPTH - 2));
  assign empty   = (count == '0);
  assign do_pop  = pop && !empty;
  assign res     = slots[rd_ptr];

  always_comb begin
    bit_accumulator_next = bit_accumulator;
    pending_bits_next    = pending_bits;
    pad_count_next       = pad_count;
    pad_seen_next        = pad_seen;
    length_mod_four_next = length_mod_four;
    failed_next          = failed;
    emit_byte            = 1'b0;
    shifted              = '0;
    sum_bits             = pending_bits + 4'd6;
    if (cmd.kind != b64d_pkg::KIND_SKIP && !failed) begin
      length_mod_four_next = length_mod_four + 1'b1;
      if (cmd.kind == b64d_pkg::KIND_PAD) begin
        pad_seen_next = 1'b1;
        if (pad_count != 2'd3) begin
          pad_count_next = pad_count + 1'b1;
        end
      end else if (pad_seen || cmd.kind == b64d_pkg::KIND_BAD) begin
        failed_next = 1'b1;
      end else begin
        bit_accumulator_next = {bit_accumulator[5:0], cmd.sextet};
        pending_bits_next    = sum_bits;
        if (sum_bits >= 4'd8) begin
          emit_byte         = 1'b1;
          pending_bits_next = sum_bits - 4'd8;
          shifted           = bit_accumulator_next >> pending_bits_next;
        end
      end
    end
    ok          = !failed_next && pad_count_next != 2'd3 && length_mod_four_next != 2'd1;
    emit_status = cmd.eos;

    byte_res.is_status  = 1'b0;
    byte_res.byte_value = shifted[7:0];
    byte_res.success    = 1'b0;
    byte_res.last       = 1'b0;

    status_res.is_status  = 1'b1;
    status_res.byte_value = '0;
    status_res.success    = ok;
    status_res.last       = 1'b1;

    n_write = {1'b0, emit_byte} + {1'b0, emit_status};
    wr_ptr1 = (wr_ptr == AW'(RES_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    wr_ptr2 = (wr_ptr1 == AW'(RES_DEPTH - 1)) ? '0 : wr_ptr1 + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      if (emit_byte) begin
        slots[wr_ptr] <= byte_res;
        if (emit_status) begin
          slots[wr_ptr1] <= status_res;
        end
      end else if (emit_status) begin
        slots[wr_ptr] <= status_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_accumulator <= '0;
      pending_bits    <= '0;
      pad_count       <= '0;
      pad_seen        <= 1'b0;
      length_mod_four <= '0;
      failed          <= 1'b0;
      wr_ptr          <= '0;
      rd_ptr          <= '0;
      count           <= '0;
    end else begin
      if (cmd_pop) begin
        if (cmd.eos) begin
          bit_accumulator <= '0;
          pending_bits    <= '0;
          pad_count       <= '0;
          pad_seen        <= 1'b0;
          length_mod_four <= '0;
          failed          <= 1'b0;
        end else begin
          bit_accumulator <= bit_accumulator_next;
          pending_bits    <= pending_bits_next;
          pad_count       <= pad_count_next;
          pad_seen        <= pad_seen_next;
          length_mod_four <= length_mod_four_next;
          failed          <= failed_next;
        end
        case (n_write)
          2'd1:    wr_ptr <= wr_ptr1;
          2'd2:    wr_ptr <= wr_ptr2;
          default: wr_ptr <= wr_ptr;
        endcase
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(RES_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (cmd_pop ? CW'(n_write) : CW'(0)) - CW'(do_pop);
    end
  end

  `B64D_ASSERT(a_res_count_bound, count <= CW'(RES_DEPTH), "Result queue overflow.")
  `B64D_ASSERT(a_pending_even,
    !pending_bits[0] && pending_bits <= 4'd6, "Pending bit count out of range.")
  `B64D_ASSERT_NEXT(a_eos_clears, cmd_pop && cmd.eos,
    pending_bits == '0 && length_mod_four == '0 && !failed && !pad_seen,
    "State not cleared after end of string.")

endmodule

`default_nettype wire

// File: hdl/base64_stream_decoder_unit.sv
// Top level of the streaming base64 decoder.
// Takes one character word per clock while full is low and decodes it on the
// fly. A pushed item enters a short command queue after its character has been
// classified; the back end takes one command per clock while the result queue
// has room for two results and writes zero, one or two result words (a data
// byte, then the status on the last item of a string) into the result queue.
// The first result of an item is registered in the command queue and then in
// the result queue before it shows on the result ports and can be popped. Input
// is sustained at one character per clock as long as results are popped; the
// pop side moves one result per clock, so an item that yields both a byte and a
// status needs a pop for each. Bytes are emitted as soon as they are complete
// and must be discarded by the user when the closing status reports failure.
`default_nettype none

module base64_stream_decoder_unit #(
  parameter int CMD_DEPTH = b64d_pkg::CMD_DEPTH,
  parameter int RES_DEPTH = b64d_pkg::RES_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] char_code,
  input  wire logic       no_char,
  input  wire logic       end_of_string,
  output logic            empty,
  input  wire logic       pop,
  output logic            is_status,
  output logic [7:0]      byte_value,
  output logic            success,
  output logic            last
);

  logic           cmd_valid;
  logic           cmd_pop;
  b64d_pkg::cmd_t cmd;
  b64d_pkg::res_t res;

  b64d_front #(
    .CMD_DEPTH(CMD_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .char_code    (char_code),
    .no_char      (no_char),
    .end_of_string(end_of_string),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  b64d_back #(
    .RES_DEPTH(RES_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .empty    (empty),
    .pop      (pop),
    .res      (res)
  );

  assign is_status  = res.is_status;
  assign byte_value = res.byte_value;
  assign success    = res.success;
  assign last       = res.last;

endmodule

`default_nettype wire
